// File: sv/vmfa_pkg.sv
package vmfa_pkg;

   localparam int AXIS_W   = 16;
   localparam int DIR_W    = 16;
   localparam int POS_W    = 32;
   localparam int VEC_W    = 33;
   localparam int NORM_LAT = 53;

   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctrl_type;

endpackage

// File: sv/vmfa_cross.sv
module vmfa_cross (
   input  logic                       clock,
   input  logic                       reset,
   input  vmfa_pkg::pipe_ctrl_type    ctl,
   input  logic signed [15:0]         fwd [3],
   input  logic signed [15:0]         rgt [3],
   input  logic signed [31:0]         eye [3],
   output logic                       valid_out,
   output logic signed [32:0]         fwd_out [3],
   output logic signed [32:0]         crs_out [3],
   output logic signed [31:0]         eye_out [3],
   output logic                       zero_out
);

   logic signed [31:0] pa [3];
   logic signed [31:0] pb [3];
   logic signed [32:0] crs_in [3];
   logic signed [32:0] fwd_in [3];
   logic               zero_in;

   logic               valid_ff;
   logic signed [32:0] crs_ff [3];
   logic signed [32:0] fwd_ff [3];
   logic signed [31:0] eye_ff [3];
   logic               zero_ff;

   always_comb begin
      pa[0] = fwd[1] * rgt[2];
      pb[0] = fwd[2] * rgt[1];
      pa[1] = fwd[2] * rgt[0];
      pb[1] = fwd[0] * rgt[2];
      pa[2] = fwd[0] * rgt[1];
      pb[2] = fwd[1] * rgt[0];
      for (int i = 0; i < 3; i++) begin
         crs_in[i] = 33'(pa[i]) - 33'(pb[i]);
         fwd_in[i] = 33'(fwd[i]);
      end
      zero_in = ((fwd[0] == 16'sd0) && (fwd[1] == 16'sd0) && (fwd[2] == 16'sd0)) ||
                ((crs_in[0] == 33'sd0) && (crs_in[1] == 33'sd0) && (crs_in[2] == 33'sd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         crs_ff  <= crs_in;
         fwd_ff  <= fwd_in;
         eye_ff  <= eye;
         zero_ff <= zero_in;
      end
   end

   assign valid_out = valid_ff;
   assign fwd_out   = fwd_ff;
   assign crs_out   = crs_ff;
   assign eye_out   = eye_ff;
   assign zero_out  = zero_ff;

endmodule

// File: sv/vmfa_norm.sv
module vmfa_norm (
   input  logic                       clock,
   input  logic                       reset,
   input  vmfa_pkg::pipe_ctrl_type    ctl,
   input  logic signed [32:0]         vec [3],
   output logic                       valid_out,
   output logic signed [15:0]         unit [3]
);

   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 15;

   // magnitudes and largest component
   logic [31:0] mag1_in [3];
   logic [31:0] max1_in;
   logic [2:0]  neg1_in;
   logic        v1_ff;
   logic [31:0] mag1_ff [3];
   logic [31:0] max1_ff;
   logic [2:0]  neg1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = vec[i][32];
         mag1_in[i] = vec[i][32] ? 32'(-vec[i]) : 32'(vec[i]);
      end
      max1_in = mag1_in[0];
      if (mag1_in[1] > max1_in) begin
         max1_in = mag1_in[1];
      end
      if (mag1_in[2] > max1_in) begin
         max1_in = mag1_in[2];
      end
   end

   // scale up to the normalising floor
   logic [4:0]  msb2;
   logic [4:0]  sh2;
   logic [31:0] w2_in [3];
   logic        v2_ff;
   logic [31:0] w2_ff [3];
   logic [2:0]  neg2_ff;

   always_comb begin
      msb2 = 5'd0;
      for (int b = 0; b < 32; b++) begin
         if (max1_ff[b]) begin
            msb2 = 5'(b);
         end
      end
      if (msb2 < 5'd29) begin
         sh2 = 5'd29 - msb2;
      end else begin
         sh2 = 5'd0;
      end
      for (int i = 0; i < 3; i++) begin
         w2_in[i] = mag1_ff[i] << sh2;
      end
   end

   // squares
   logic [63:0] sq3_in [3];
   logic        v3_ff;
   logic [63:0] sq3_ff [3];
   logic [31:0] w3_ff [3];
   logic [2:0]  neg3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq3_in[i] = w2_ff[i] * w2_ff[i];
      end
   end

   // square root, one result bit per stage
   logic        sqv_ff  [0:SQ_STEPS];
   logic [63:0] rad_ff  [0:SQ_STEPS];
   logic [31:0] root_ff [0:SQ_STEPS];
   logic [33:0] rem_ff  [0:SQ_STEPS];
   logic [31:0] sw_ff   [0:SQ_STEPS][3];
   logic [2:0]  sneg_ff [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         sqv_ff[0] <= 1'b0;
      end else if (ctl.en) begin
         v1_ff     <= ctl.valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         sqv_ff[0] <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         mag1_ff    <= mag1_in;
         max1_ff    <= max1_in;
         neg1_ff    <= neg1_in;
         w2_ff      <= w2_in;
         neg2_ff    <= neg1_ff;
         sq3_ff     <= sq3_in;
         w3_ff      <= w2_ff;
         neg3_ff    <= neg2_ff;
         rad_ff[0]  <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
         root_ff[0] <= 32'd0;
         rem_ff[0]  <= 34'd0;
         sw_ff[0]   <= w3_ff;
         sneg_ff[0] <= neg3_ff;
      end
   end

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      logic [35:0] rem_t;
      logic [35:0] trial;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      always_comb begin
         rem_t = {rem_ff[j], rad_ff[j][63:62]};
         trial = {2'b00, root_ff[j], 2'b01};
         if (rem_t >= trial) begin
            rem_in  = 34'(rem_t - trial);
            root_in = {root_ff[j][30:0], 1'b1};
         end else begin
            rem_in  = rem_t[33:0];
            root_in = {root_ff[j][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[j+1] <= 1'b0;
         end else if (ctl.en) begin
            sqv_ff[j+1] <= sqv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rad_ff[j+1]  <= rad_ff[j] << 2;
            root_ff[j+1] <= root_in;
            rem_ff[j+1]  <= rem_in;
            sw_ff[j+1]   <= sw_ff[j];
            sneg_ff[j+1] <= sneg_ff[j];
         end
      end
   end

   // rounded division by the length, one quotient bit per stage
   logic        dv_ff   [0:DIV_STEPS];
   logic [31:0] dlen_ff [0:DIV_STEPS];
   logic [31:0] drem_ff [0:DIV_STEPS][3];
   logic [14:0] dlo_ff  [0:DIV_STEPS][3];
   logic [14:0] dq_ff   [0:DIV_STEPS][3];
   logic [2:0]  dneg_ff [0:DIV_STEPS];
   logic [45:0] num_in  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = ({14'd0, sw_ff[SQ_STEPS][i]} << 14) + 46'(root_ff[SQ_STEPS] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (ctl.en) begin
         dv_ff[0] <= sqv_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         dlen_ff[0] <= root_ff[SQ_STEPS];
         dneg_ff[0] <= sneg_ff[SQ_STEPS];
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= {1'b0, num_in[i][45:15]};
            dlo_ff[0][i]  <= num_in[i][14:0];
            dq_ff[0][i]   <= 15'd0;
         end
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [32:0] r2 [3];
      logic [31:0] drem_in [3];
      logic [14:0] dq_in [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            r2[i] = {drem_ff[k][i], dlo_ff[k][i][14]};
            if (r2[i] >= {1'b0, dlen_ff[k]}) begin
               drem_in[i] = 32'(r2[i] - {1'b0, dlen_ff[k]});
               dq_in[i]   = {dq_ff[k][i][13:0], 1'b1};
            end else begin
               drem_in[i] = r2[i][31:0];
               dq_in[i]   = {dq_ff[k][i][13:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (ctl.en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            dlen_ff[k+1] <= dlen_ff[k];
            dneg_ff[k+1] <= dneg_ff[k];
            drem_ff[k+1] <= drem_in;
            dq_ff[k+1]   <= dq_in;
            for (int i = 0; i < 3; i++) begin
               dlo_ff[k+1][i] <= {dlo_ff[k][i][13:0], 1'b0};
            end
         end
      end
   end

   // sign and clamp to plus or minus one
   logic [14:0]        qc [3];
   logic signed [15:0] unit_in [3];
   logic               uv_ff;
   logic signed [15:0] unit_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc[i] = (dq_ff[DIV_STEPS][i] > 15'd16384) ? 15'd16384 : dq_ff[DIV_STEPS][i];
         unit_in[i] = dneg_ff[DIV_STEPS][i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_ff <= 1'b0;
      end else if (ctl.en) begin
         uv_ff <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         unit_ff <= unit_in;
      end
   end

   assign valid_out = uv_ff;
   assign unit      = unit_ff;

endmodule

// File: sv/vmfa_back.sv
module vmfa_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vmfa_pkg::pipe_ctrl_type    ctl,
   input  logic signed [15:0]         u [3],
   input  logic signed [15:0]         f [3],
   input  logic signed [31:0]         eye [3],
   input  logic                       zero,
   output logic                       valid_out,
   output logic signed [15:0]         r_out [3],
   output logic signed [15:0]         u_out [3],
   output logic signed [15:0]         f_out [3],
   output logic signed [31:0]         shift_out [3]
);

   // right axis as up cross forward
   logic signed [31:0] pa [3];
   logic signed [31:0] pb [3];
   logic signed [32:0] t_in [3];
   logic               v1_ff;
   logic signed [32:0] t_ff [3];
   logic signed [15:0] u1_ff [3];
   logic signed [15:0] f1_ff [3];
   logic signed [31:0] e1_ff [3];
   logic               z1_ff;

   always_comb begin
      pa[0] = u[1] * f[2];
      pb[0] = u[2] * f[1];
      pa[1] = u[2] * f[0];
      pb[1] = u[0] * f[2];
      pa[2] = u[0] * f[1];
      pb[2] = u[1] * f[0];
      for (int i = 0; i < 3; i++) begin
         t_in[i] = 33'(pa[i]) - 33'(pb[i]);
      end
   end

   // round back to q2.14
   logic [32:0]        tm [3];
   logic [18:0]        tq [3];
   logic [14:0]        tc [3];
   logic signed [15:0] r_in [3];
   logic               v2_ff;
   logic signed [15:0] r2_ff [3];
   logic signed [15:0] u2_ff [3];
   logic signed [15:0] f2_ff [3];
   logic signed [31:0] e2_ff [3];
   logic               z2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tm[i] = t_ff[i][32] ? 33'(-t_ff[i]) : 33'(t_ff[i]);
         tq[i] = 19'((tm[i] + 33'd8192) >> 14);
         tc[i] = (tq[i] > 19'd16384) ? 15'd16384 : tq[i][14:0];
         r_in[i] = t_ff[i][32] ? -$signed({1'b0, tc[i]}) : $signed({1'b0, tc[i]});
      end
   end

   // position products
   logic signed [47:0] pr_in [3];
   logic signed [47:0] pu_in [3];
   logic signed [47:0] pf_in [3];
   logic               v3_ff;
   logic signed [47:0] pr_ff [3];
   logic signed [47:0] pu_ff [3];
   logic signed [47:0] pf_ff [3];
   logic signed [15:0] r3_ff [3];
   logic signed [15:0] u3_ff [3];
   logic signed [15:0] f3_ff [3];
   logic               z3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pr_in[i] = e2_ff[i] * r2_ff[i];
         pu_in[i] = e2_ff[i] * u2_ff[i];
         pf_in[i] = e2_ff[i] * f2_ff[i];
      end
   end

   // sums, rounding, negation and saturation
   logic signed [49:0] dot [3];
   logic [49:0]        dm [3];
   logic [35:0]        dq [3];
   logic signed [36:0] ds [3];
   logic signed [31:0] sh_in [3];
   logic               v4_ff;
   logic signed [15:0] r4_ff [3];
   logic signed [15:0] u4_ff [3];
   logic signed [15:0] f4_ff [3];
   logic signed [31:0] sh4_ff [3];

   always_comb begin
      dot[0] = 50'(pr_ff[0]) + 50'(pr_ff[1]) + 50'(pr_ff[2]);
      dot[1] = 50'(pu_ff[0]) + 50'(pu_ff[1]) + 50'(pu_ff[2]);
      dot[2] = 50'(pf_ff[0]) + 50'(pf_ff[1]) + 50'(pf_ff[2]);
      for (int i = 0; i < 3; i++) begin
         dm[i] = dot[i][49] ? 50'(-dot[i]) : 50'(dot[i]);
         dq[i] = 36'((dm[i] + 50'd8192) >> 14);
         ds[i] = dot[i][49] ? $signed({1'b0, dq[i]}) : -$signed({1'b0, dq[i]});
         if (ds[i] > 37'sd2147483647) begin
            sh_in[i] = 32'sh7fffffff;
         end else if (ds[i] < -37'sd2147483648) begin
            sh_in[i] = 32'sh80000000;
         end else begin
            sh_in[i] = ds[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (ctl.en) begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         t_ff  <= t_in;
         u1_ff <= u;
         f1_ff <= f;
         e1_ff <= eye;
         z1_ff <= zero;
         r2_ff <= r_in;
         u2_ff <= u1_ff;
         f2_ff <= f1_ff;
         e2_ff <= e1_ff;
         z2_ff <= z1_ff;
         pr_ff <= pr_in;
         pu_ff <= pu_in;
         pf_ff <= pf_in;
         r3_ff <= r2_ff;
         u3_ff <= u2_ff;
         f3_ff <= f2_ff;
         z3_ff <= z2_ff;
         for (int i = 0; i < 3; i++) begin
            r4_ff[i]  <= z3_ff ? 16'sd0 : r3_ff[i];
            u4_ff[i]  <= z3_ff ? 16'sd0 : u3_ff[i];
            f4_ff[i]  <= z3_ff ? 16'sd0 : f3_ff[i];
            sh4_ff[i] <= z3_ff ? 32'sd0 : sh_in[i];
         end
      end
   end

   assign valid_out = v4_ff;
   assign r_out     = r4_ff;
   assign u_out     = u4_ff;
   assign f_out     = f4_ff;
   assign shift_out = sh4_ff;

endmodule

// File: sv/view_matrix_from_axes_unit.sv
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | forward, right hint, eye
// rsp     | out       | rsp_valid/rsp_stall | axes r/u/f, shifts r/u/f
//
// one beat in per cycle while no rsp beat is held
// each normaliser holds a 32-stage square root and a 15-stage divider
// reset is synchronous and clears every stage valid
// a held rsp beat freezes the whole pipe and raises req_stall
module view_matrix_from_axes_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_forward_x,
   input  logic signed [15:0] req_forward_y,
   input  logic signed [15:0] req_forward_z,
   input  logic signed [15:0] req_right_hint_x,
   input  logic signed [15:0] req_right_hint_y,
   input  logic signed [15:0] req_right_hint_z,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_axis_r_x,
   output logic signed [15:0] rsp_axis_r_y,
   output logic signed [15:0] rsp_axis_r_z,
   output logic signed [15:0] rsp_axis_u_x,
   output logic signed [15:0] rsp_axis_u_y,
   output logic signed [15:0] rsp_axis_u_z,
   output logic signed [15:0] rsp_axis_f_x,
   output logic signed [15:0] rsp_axis_f_y,
   output logic signed [15:0] rsp_axis_f_z,
   output logic signed [31:0] rsp_shift_r,
   output logic signed [31:0] rsp_shift_u,
   output logic signed [31:0] rsp_shift_f
);

   localparam int LAT = vmfa_pkg::NORM_LAT;

   logic                    adv;
   vmfa_pkg::pipe_ctrl_type cross_ctl;
   vmfa_pkg::pipe_ctrl_type norm_ctl;
   vmfa_pkg::pipe_ctrl_type back_ctl;

   logic signed [15:0] fwd [3];
   logic signed [15:0] rgt [3];
   logic signed [31:0] eye [3];

   logic               c_valid;
   logic signed [32:0] c_fwd [3];
   logic signed [32:0] c_crs [3];
   logic signed [31:0] c_eye [3];
   logic               c_zero;

   logic               nf_valid;
   logic               nu_valid;
   logic signed [15:0] nf_unit [3];
   logic signed [15:0] nu_unit [3];

   logic signed [31:0] eye_dl_ff  [0:LAT-1][3];
   logic               zero_dl_ff [0:LAT-1];

   logic               b_valid;
   logic signed [15:0] b_r [3];
   logic signed [15:0] b_u [3];
   logic signed [15:0] b_f [3];
   logic signed [31:0] b_sh [3];

   assign adv       = !(b_valid && rsp_stall);
   assign req_stall = !adv;

   assign fwd[0] = req_forward_x;
   assign fwd[1] = req_forward_y;
   assign fwd[2] = req_forward_z;
   assign rgt[0] = req_right_hint_x;
   assign rgt[1] = req_right_hint_y;
   assign rgt[2] = req_right_hint_z;
   assign eye[0] = req_eye_x;
   assign eye[1] = req_eye_y;
   assign eye[2] = req_eye_z;

   assign cross_ctl = '{en: adv, valid: req_valid};
   assign norm_ctl  = '{en: adv, valid: c_valid};
   assign back_ctl  = '{en: adv, valid: nf_valid};

   vmfa_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cross_ctl),
      .fwd       (fwd),
      .rgt       (rgt),
      .eye       (eye),
      .valid_out (c_valid),
      .fwd_out   (c_fwd),
      .crs_out   (c_crs),
      .eye_out   (c_eye),
      .zero_out  (c_zero)
   );

   vmfa_norm u_norm_f (
      .clock     (clock),
      .reset     (reset),
      .ctl       (norm_ctl),
      .vec       (c_fwd),
      .valid_out (nf_valid),
      .unit      (nf_unit)
   );

   vmfa_norm u_norm_u (
      .clock     (clock),
      .reset     (reset),
      .ctl       (norm_ctl),
      .vec       (c_crs),
      .valid_out (nu_valid),
      .unit      (nu_unit)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         eye_dl_ff[0]  <= c_eye;
         zero_dl_ff[0] <= c_zero;
         for (int j = 1; j < LAT; j++) begin
            eye_dl_ff[j]  <= eye_dl_ff[j-1];
            zero_dl_ff[j] <= zero_dl_ff[j-1];
         end
      end
   end

   vmfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ctl       (back_ctl),
      .u         (nu_unit),
      .f         (nf_unit),
      .eye       (eye_dl_ff[LAT-1]),
      .zero      (zero_dl_ff[LAT-1]),
      .valid_out (b_valid),
      .r_out     (b_r),
      .u_out     (b_u),
      .f_out     (b_f),
      .shift_out (b_sh)
   );

   assign rsp_valid    = b_valid;
   assign rsp_axis_r_x = b_r[0];
   assign rsp_axis_r_y = b_r[1];
   assign rsp_axis_r_z = b_r[2];
   assign rsp_axis_u_x = b_u[0];
   assign rsp_axis_u_y = b_u[1];
   assign rsp_axis_u_z = b_u[2];
   assign rsp_axis_f_x = b_f[0];
   assign rsp_axis_f_y = b_f[1];
   assign rsp_axis_f_z = b_f[2];
   assign rsp_shift_r  = b_sh[0];
   assign rsp_shift_u  = b_sh[1];
   assign rsp_shift_f  = b_sh[2];

`ifndef ASSERT_OFF
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_stall_back : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("held beat did not stall the input");

   a_norm_align : assert property (@(posedge clock) disable iff (reset)
      nf_valid == nu_valid)
      else $error("normaliser valids out of step");

   a_f_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_axis_f_x <= 16'sd16384 && rsp_axis_f_x >= -16'sd16384 &&
                     rsp_axis_f_y <= 16'sd16384 && rsp_axis_f_y >= -16'sd16384 &&
                     rsp_axis_f_z <= 16'sd16384 && rsp_axis_f_z >= -16'sd16384))
      else $error("forward axis beyond unit range");

   a_u_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_axis_u_x <= 16'sd16384 && rsp_axis_u_x >= -16'sd16384 &&
                     rsp_axis_u_y <= 16'sd16384 && rsp_axis_u_y >= -16'sd16384 &&
                     rsp_axis_u_z <= 16'sd16384 && rsp_axis_u_z >= -16'sd16384))
      else $error("up axis beyond unit range");
`endif

endmodule

// File: dv/view_matrix_from_axes_unit_tb.sv
`timescale 1ns / 1ps

module view_matrix_from_axes_unit_tb;

   typedef struct packed {
      logic signed [15:0] fx, fy, fz;
      logic signed [15:0] hx, hy, hz;
      logic signed [31:0] ex, ey, ez;
   } camera_type;

   typedef struct packed {
      logic signed [15:0] rx, ry, rz;
      logic signed [15:0] ux, uy, uz;
      logic signed [15:0] fx, fy, fz;
      logic signed [31:0] sr, su, sf;
   } view_type;

   typedef struct {
      camera_type cam;
      bit         fixed;
      view_type   want;
   } directed_row_type;

   localparam longint ONE_Q14 = 16384;
   localparam int     QUIET_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   camera_type cam_drv = '0;
   view_type got;

   view_type expected_views[$];
   int errors = 0;
   int checked = 0;
   int degenerate_seen = 0;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   view_matrix_from_axes_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_forward_x(cam_drv.fx), .req_forward_y(cam_drv.fy), .req_forward_z(cam_drv.fz),
      .req_right_hint_x(cam_drv.hx), .req_right_hint_y(cam_drv.hy),
      .req_right_hint_z(cam_drv.hz),
      .req_eye_x(cam_drv.ex), .req_eye_y(cam_drv.ey), .req_eye_z(cam_drv.ez),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_axis_r_x(got.rx), .rsp_axis_r_y(got.ry), .rsp_axis_r_z(got.rz),
      .rsp_axis_u_x(got.ux), .rsp_axis_u_y(got.uy), .rsp_axis_u_z(got.uz),
      .rsp_axis_f_x(got.fx), .rsp_axis_f_y(got.fy), .rsp_axis_f_z(got.fz),
      .rsp_shift_r(got.sr), .rsp_shift_u(got.su), .rsp_shift_f(got.sf)
   );

   function automatic longint round_div(longint num, longint den);
      longint q;
      q = ((num < 0 ? -num : num) + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic longint clamp_one(longint v);
      return v < -ONE_Q14 ? -ONE_Q14 : (v > ONE_Q14 ? ONE_Q14 : v);
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void unit_vector(input longint v[3], output longint o[3]);
      longint unsigned m, s2, a;
      longint w[3];
      longint len;
      int sh;
      m = 0;
      s2 = 0;
      sh = 0;
      for (int i = 0; i < 3; i++) begin
         a = v[i] < 0 ? -v[i] : v[i];
         if (a > m) m = a;
      end
      while ((m << sh) < (64'd1 << 29)) sh++;
      for (int i = 0; i < 3; i++) begin
         w[i] = v[i] <<< sh;
         a = w[i] < 0 ? -w[i] : w[i];
         s2 += a * a;
      end
      len = int_sqrt(s2);
      for (int i = 0; i < 3; i++) o[i] = clamp_one(round_div(w[i] * ONE_Q14, len));
   endfunction

   function automatic void cross_prod(input longint a[3], input longint b[3],
                                      output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic logic [31:0] translation(longint e[3], longint ax[3]);
      longint t;
      t = -round_div(e[0] * ax[0] + e[1] * ax[1] + e[2] * ax[2], ONE_Q14);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[31:0];
   endfunction

   function automatic view_type look_at(camera_type c);
      longint f[3], h[3], e[3], x[3], ff[3], uu[3], t[3], rr[3];
      view_type v;
      v = '0;
      f = '{c.fx, c.fy, c.fz};
      h = '{c.hx, c.hy, c.hz};
      e = '{c.ex, c.ey, c.ez};
      cross_prod(f, h, x);
      if ((f[0] == 0 && f[1] == 0 && f[2] == 0) || (x[0] == 0 && x[1] == 0 && x[2] == 0))
         return v;
      unit_vector(f, ff);
      unit_vector(x, uu);
      cross_prod(uu, ff, t);
      for (int i = 0; i < 3; i++) rr[i] = clamp_one(round_div(t[i], ONE_Q14));
      v.rx = 16'(rr[0]); v.ry = 16'(rr[1]); v.rz = 16'(rr[2]);
      v.ux = 16'(uu[0]); v.uy = 16'(uu[1]); v.uz = 16'(uu[2]);
      v.fx = 16'(ff[0]); v.fy = 16'(ff[1]); v.fz = 16'(ff[2]);
      v.sr = translation(e, rr);
      v.su = translation(e, uu);
      v.sf = translation(e, ff);
      return v;
   endfunction

   function automatic camera_type random_camera();
      camera_type c;
      int k;
      c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      k = $urandom_range(0, 9);
      if (k == 0) begin
         c.fx = 0; c.fy = 0; c.fz = 0;
      end else if (k == 1) begin
         c.hx = c.fx * 2; c.hy = c.fy * 2; c.hz = c.fz * 2;
      end else if (k == 2) begin
         c.fx = 16'($signed($urandom_range(0, 15)) - 8);
         c.fy = 16'($signed($urandom_range(0, 15)) - 8);
         c.fz = 16'($signed($urandom_range(0, 15)) - 8);
      end else if (k == 3) begin
         c.hx = 16'($signed($urandom_range(0, 3)) - 2);
         c.hy = 16'($signed($urandom_range(0, 3)) - 2);
         c.hz = 16'($signed($urandom_range(0, 3)) - 2);
      end else if (k == 4) begin
         c.ex = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         c.ey = c.ex;
         c.ez = c.ex;
      end
      return c;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   task automatic send_camera(camera_type c);
      int g;
      g = gap_length();
      repeat (g) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      cam_drv <= c;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_views.push_back(look_at(c));
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      int g;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 15) begin
         g = gap_length() + 1;
         rsp_stall <= 1'b1;
         repeat (g) @(negedge clock);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      view_type want;
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && !req_stall) quiet_cycles = 0;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            checked++;
            if (expected_views.size() == 0) begin
               if (errors < 10) $display("unexpected beat %p", got);
               errors++;
            end else begin
               want = expected_views.pop_front();
               if (want == '0) degenerate_seen++;
               if (want !== got) begin
                  if (errors < 10) $display("mismatch exp %p got %p", want, got);
                  errors++;
               end
            end
         end
         if (quiet_cycles > QUIET_LIMIT) begin
            $display("timeout waiting for handshake");
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   directed_row_type rows[$];

   initial begin
      camera_type c;
      view_type any;
      any = '0;
      rows.push_back('{'{16'sd4096, 0, 0, 0, 16'sd4096, 0, 0, 0, 0}, 1'b1,
                      '{0, 16'sd16384, 0, 0, 0, 16'sd16384, 16'sd16384, 0, 0, 0, 0, 0}});
      rows.push_back('{'{0, 0, 0, 16'sd4096, 0, 0, 32'sd65536, 0, 0}, 1'b1, '0});
      rows.push_back('{'{16'sd100, 16'sd200, 16'sd300, 16'sd200, 16'sd400, 16'sd600,
                         1, 2, 3}, 1'b1, '0});
      rows.push_back('{'{16'sd4096, 16'sd4096, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '0});
      rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 0,
                         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, any});
      rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                         32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, any});
      rows.push_back('{'{16'sh8000, 0, 0, 0, 16'sh8000, 0,
                         32'sh80000000, 0, 0}, 1'b0, any});
      rows.push_back('{'{1, 0, 0, 0, 1, 0, 32'sh7fffffff, 0, 0}, 1'b0, any});
      rows.push_back('{'{1, 1, 1, 1, -1, 0, -1, -1, -1}, 1'b0, any});
      rows.push_back('{'{-1, -1, 16'sh7fff, 16'sh7fff, -1, 16'sh8000,
                         32'sh7fffffff, 32'sh80000000, 0}, 1'b0, any});
      rows.push_back('{'{16'sh5555, 16'shaaaa, 16'sh1234, 16'shaaaa, 16'sh5555, 16'shfedc,
                         32'sh55555555, 32'shaaaaaaaa, 32'sh12345678}, 1'b0, any});
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         if (rows[i].fixed && look_at(rows[i].cam) !== rows[i].want) begin
            errors++;
            $display("directed row %0d disagrees with its typed result", i);
         end
         send_camera(rows[i].cam);
      end
      for (int n = 0; n < 500; n++) begin
         if (n == 250) begin
            req_valid <= 1'b0;
            while (expected_views.size() != 0) @(negedge clock);
         end
         c = random_camera();
         send_camera(c);
      end
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("%0d view set-ups checked, %0d of them degenerate", checked, degenerate_seen);
      $display("covered field extremes, zero and parallel vectors, saturated shifts");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
